@@ sv/tlg_pkg.sv @@
`timescale 1ns / 1ps

package tlg_pkg;

    localparam int CellW    = 64;
    localparam int CellIdxW = 6;
    localparam int SideW    = 7;
    localparam int RowNumW  = 6;

    localparam logic [SideW-1:0] GridSideReset = 7'd64;
    localparam logic [SideW-1:0] SideMin       = 7'd3;

    // neighbor counts of rule B3/S23
    localparam logic [3:0] BirthCount   = 4'd3;
    localparam logic [3:0] SurviveCount = 4'd2;

    typedef logic [CellW-1:0] row_t;

    // one loaded frame waiting to be evolved
    typedef struct packed {
        logic             bank;
        logic [SideW-1:0] side;
    } job_t;

    // ones at every cell index below the active side
    function automatic row_t row_mask(input logic [SideW-1:0] side);
        row_t mask;
        for (int i = 0; i < CellW; i++) begin
            mask[i] = (SideW'(i) < side);
        end
        return mask;
    endfunction

endpackage

@@ sv/tlg_ram.sv @@
`timescale 1ns / 1ps

module tlg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/tlg_front.sv @@
`timescale 1ns / 1ps

module tlg_front #(
    parameter int MAX_SIDE = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tlg_pkg::SideW-1:0]       cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tlg_pkg::row_t                   s_row_cells,
    output logic                            ram_wr_en,
    output logic [$clog2(2*MAX_SIDE)-1:0]   ram_wr_addr,
    output tlg_pkg::row_t                   ram_wr_data,
    output logic                            job_push,
    output tlg_pkg::job_t                   job_out,
    input  logic                            bank_release
);

    localparam int ROW_W  = $clog2(MAX_SIDE);
    localparam int ADDR_W = $clog2(2*MAX_SIDE);
    localparam logic [tlg_pkg::SideW-1:0] MaxSide = tlg_pkg::SideW'(MAX_SIDE);

    logic [tlg_pkg::SideW-1:0] grid_side_reg, grid_side_next;
    logic [tlg_pkg::SideW-1:0] rows_loaded_reg, rows_loaded_next;
    logic                      wr_bank_reg, wr_bank_next;
    logic [1:0]                busy_reg, busy_next;
    logic [tlg_pkg::SideW-1:0] side_act;
    logic                      accept;
    logic                      last_row;

    always_comb begin
        if (grid_side_reg < tlg_pkg::SideMin) begin
            side_act = tlg_pkg::SideMin;
        end else if (grid_side_reg > MaxSide) begin
            side_act = MaxSide;
        end else begin
            side_act = grid_side_reg;
        end
    end

    // both banks taken: hold the input until the back end frees one
    assign s_ready  = (busy_reg != 2'd2);
    assign accept   = s_valid && s_ready;
    assign last_row = (rows_loaded_reg + 1'b1) == side_act;

    assign ram_wr_en   = accept;
    assign ram_wr_addr = (wr_bank_reg ? ADDR_W'(MAX_SIDE) : ADDR_W'(0))
                       + ADDR_W'(rows_loaded_reg[ROW_W-1:0]);
    assign ram_wr_data = s_row_cells & tlg_pkg::row_mask(side_act);

    assign job_push = accept && last_row;
    assign job_out  = '{bank: wr_bank_reg, side: side_act};

    always_comb begin
        grid_side_next   = grid_side_reg;
        rows_loaded_next = rows_loaded_reg;
        wr_bank_next     = wr_bank_reg;
        busy_next        = busy_reg + {1'b0, job_push} - {1'b0, bank_release};
        if (cfg_wr_en) begin
            // drop any partly loaded frame
            grid_side_next   = cfg_wr_data;
            rows_loaded_next = '0;
        end else if (accept) begin
            if (last_row) begin
                rows_loaded_next = '0;
                wr_bank_next     = ~wr_bank_reg;
            end else begin
                rows_loaded_next = rows_loaded_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_side_reg   <= tlg_pkg::GridSideReset;
            rows_loaded_reg <= '0;
            wr_bank_reg     <= 1'b0;
            busy_reg        <= '0;
        end else begin
            grid_side_reg   <= grid_side_next;
            rows_loaded_reg <= rows_loaded_next;
            wr_bank_reg     <= wr_bank_next;
            busy_reg        <= busy_next;
        end
    end

endmodule

@@ sv/tlg_job_fifo.sv @@
`timescale 1ns / 1ps

module tlg_job_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tlg_pkg::job_t push_data,
    input  logic          pop,
    output logic          empty,
    output tlg_pkg::job_t head
);

    tlg_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ sv/tlg_back.sv @@
`timescale 1ns / 1ps

module tlg_back #(
    parameter int MAX_SIDE = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            job_empty,
    input  tlg_pkg::job_t                   job_head,
    output logic                            job_pop,
    output logic                            ram_rd_en,
    output logic [$clog2(2*MAX_SIDE)-1:0]   ram_rd_addr,
    input  tlg_pkg::row_t                   ram_rd_data,
    output logic                            bank_release,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tlg_pkg::row_t                   m_next_row_cells,
    output logic [tlg_pkg::RowNumW-1:0]     m_row_number,
    output logic                            m_frame_end
);

    localparam int ROW_W  = $clog2(MAX_SIDE);
    localparam int ADDR_W = $clog2(2*MAX_SIDE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic                      bank_reg;
    logic [tlg_pkg::SideW-1:0] side_reg;
    logic [ROW_W-1:0]          y_reg;
    logic [ROW_W-1:0]          rd_row_reg;
    logic [1:0]                fill_reg;
    tlg_pkg::row_t             up_reg, mid_reg, down_reg;
    logic                      m_valid_reg;
    tlg_pkg::row_t             next_cells_reg;
    logic [tlg_pkg::RowNumW-1:0] row_number_reg;
    logic                      frame_end_reg;

    logic [tlg_pkg::SideW-1:0] side_m1;
    logic [ROW_W-1:0]          rd_row_wrap;
    logic                      out_free;
    logic                      last_row;
    logic                      emit;

    function automatic tlg_pkg::row_t life_next(
        input tlg_pkg::row_t             up,
        input tlg_pkg::row_t             mid,
        input tlg_pkg::row_t             down,
        input logic [tlg_pkg::SideW-1:0] side
    );
        tlg_pkg::row_t                nb [8];
        tlg_pkg::row_t                res;
        logic [tlg_pkg::CellIdxW-1:0] wrap_idx;
        logic [3:0]                   count;
        wrap_idx = tlg_pkg::CellIdxW'(side - 1'b1);
        // west neighbors: shift up, cell 0 wraps to the last active cell
        nb[0] = up << 1;
        nb[0][0] = up[wrap_idx];
        nb[3] = mid << 1;
        nb[3][0] = mid[wrap_idx];
        nb[5] = down << 1;
        nb[5][0] = down[wrap_idx];
        // east neighbors: shift down, last active cell wraps to cell 0
        nb[2] = up >> 1;
        nb[2][wrap_idx] = up[0];
        nb[4] = mid >> 1;
        nb[4][wrap_idx] = mid[0];
        nb[7] = down >> 1;
        nb[7][wrap_idx] = down[0];
        nb[1] = up;
        nb[6] = down;
        for (int x = 0; x < tlg_pkg::CellW; x++) begin
            count = 4'({3'b0, nb[0][x]} + {3'b0, nb[1][x]} + {3'b0, nb[2][x]}
                     + {3'b0, nb[3][x]} + {3'b0, nb[4][x]} + {3'b0, nb[5][x]}
                     + {3'b0, nb[6][x]} + {3'b0, nb[7][x]});
            res[x] = (count == tlg_pkg::BirthCount)
                  || (mid[x] && count == tlg_pkg::SurviveCount);
        end
        return res & tlg_pkg::row_mask(side);
    endfunction

    assign side_m1     = side_reg - 1'b1;
    assign rd_row_wrap = (tlg_pkg::SideW'(rd_row_reg) == side_m1) ? '0 : rd_row_reg + 1'b1;
    assign last_row    = (tlg_pkg::SideW'(y_reg) == side_m1);
    assign out_free    = !m_valid_reg || m_ready;
    assign emit        = (state_reg == ST_EMIT) && out_free;

    assign job_pop      = (state_reg == ST_IDLE) && !job_empty;
    assign bank_release = emit && last_row;

    // fetch the row below the next output row while this one goes out
    assign ram_rd_en   = (state_reg == ST_READ) || (emit && !last_row);
    assign ram_rd_addr = (bank_reg ? ADDR_W'(MAX_SIDE) : ADDR_W'(0)) + ADDR_W'(rd_row_reg);

    assign m_valid          = m_valid_reg;
    assign m_next_row_cells = next_cells_reg;
    assign m_row_number     = row_number_reg;
    assign m_frame_end      = frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            fill_reg    <= '0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!job_empty) begin
                        bank_reg   <= job_head.bank;
                        side_reg   <= job_head.side;
                        rd_row_reg <= ROW_W'(job_head.side - 1'b1);
                        y_reg      <= '0;
                        fill_reg   <= '0;
                        state_reg  <= ST_READ;
                    end
                end
                ST_READ: begin
                    rd_row_reg <= rd_row_wrap;
                    state_reg  <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    up_reg   <= mid_reg;
                    mid_reg  <= down_reg;
                    down_reg <= ram_rd_data;
                    if (fill_reg == 2'd2) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        fill_reg  <= fill_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        next_cells_reg <= life_next(up_reg, mid_reg, down_reg, side_reg);
                        row_number_reg <= tlg_pkg::RowNumW'(y_reg);
                        frame_end_reg  <= last_row;
                        m_valid_reg    <= 1'b1;
                        if (last_row) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            y_reg      <= y_reg + 1'b1;
                            rd_row_reg <= rd_row_wrap;
                            state_reg  <= ST_SHIFT;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/toroidal_life_generation_top.sv @@
`timescale 1ns / 1ps

// Channel     | Ports                                          | Direction
// ------------+------------------------------------------------+----------
// input rows  | s_valid, s_ready, s_row_cells                  | in
// result rows | m_valid, m_ready, m_next_row_cells,            | out
//             | m_row_number, m_frame_end                      |
// config      | cfg_wr_en, cfg_wr_data (grid_side)             | in
//
// Input rows load at one per cycle into one of two grid banks in a shared RAM.
// Each finished frame is queued; the back end reads rows through the RAM's
// single read port, primes a three-row window in three read-shift steps, then
// emits rows (read of the next row overlaps the output register load).
// Two banks let the next frame load while the current one is emitted.
// Reset needs no clearing pass. A full output register stalls the back; the
// input stalls only while both banks hold frames.

module toroidal_life_generation_top #(
    parameter int MAX_SIDE = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [tlg_pkg::SideW-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tlg_pkg::CellW-1:0]   s_row_cells,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tlg_pkg::CellW-1:0]   m_next_row_cells,
    output logic [tlg_pkg::RowNumW-1:0] m_row_number,
    output logic                        m_frame_end
);

    localparam int ADDR_W = $clog2(2*MAX_SIDE);

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    tlg_pkg::row_t     ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    tlg_pkg::row_t     ram_rd_data;
    logic              job_push;
    tlg_pkg::job_t     job_in;
    logic              job_pop;
    logic              job_empty;
    tlg_pkg::job_t     job_head;
    logic              bank_release;

    tlg_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_row_cells  (s_row_cells),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .job_push     (job_push),
        .job_out      (job_in),
        .bank_release (bank_release)
    );

    tlg_ram #(
        .WIDTH (tlg_pkg::CellW),
        .DEPTH (2*MAX_SIDE)
    ) u_grid_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    tlg_job_fifo u_job_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .empty     (job_empty),
        .head      (job_head)
    );

    tlg_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .job_empty        (job_empty),
        .job_head         (job_head),
        .job_pop          (job_pop),
        .ram_rd_en        (ram_rd_en),
        .ram_rd_addr      (ram_rd_addr),
        .ram_rd_data      (ram_rd_data),
        .bank_release     (bank_release),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_next_row_cells (m_next_row_cells),
        .m_row_number     (m_row_number),
        .m_frame_end      (m_frame_end)
    );

endmodule

@@ tb/sv/toroidal_life_generation_top_test.sv @@
`timescale 1ns / 1ps

module toroidal_life_generation_top_test;

    typedef struct {
        tlg_pkg::row_t               cells;
        logic [tlg_pkg::RowNumW-1:0] num;
        logic                        last;
    } gen_row_t;

    typedef struct packed {
        bit                        is_cfg;
        logic [tlg_pkg::SideW-1:0] side_val;
        int unsigned               reps;
        tlg_pkg::row_t             cells;
        bit                        fixed;
        tlg_pkg::row_t             fixed_next;
    } dir_step_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [tlg_pkg::SideW-1:0]   cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    tlg_pkg::row_t               s_row_cells;
    logic                        m_valid;
    logic                        m_ready;
    tlg_pkg::row_t               m_next_row_cells;
    logic [tlg_pkg::RowNumW-1:0] m_row_number;
    logic                        m_frame_end;

    // side register copy and the frame being loaded
    logic [tlg_pkg::SideW-1:0] side_reg;
    tlg_pkg::row_t             frame_rows [64];
    int                        rows_in_frame;
    gen_row_t                  pending_rows [$];

    int errors;
    int rand_rows_sent;
    bit tx_burst;
    bit rx_burst;
    bit rx_hold_req;

    dir_step_t dir_steps [20] = '{
        // default side after reset: a full torus dies of overcrowding
        '{1'b0, 7'd0,    32'd64, {tlg_pkg::CellW{1'b1}}, 1'b1, 64'd0},
        '{1'b1, tlg_pkg::SideMin, 32'd0,  64'd0,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd3,  64'd0,         1'b1, 64'd0},
        '{1'b0, 7'd0,    32'd3,  {tlg_pkg::CellW{1'b1}}, 1'b1, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'h2,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'hFFFF_FFFF_FFFF_FFFA, 1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'h8000_0000_0000_0002, 1'b0, 64'd0},
        // below the minimum side
        '{1'b1, 7'd0,    32'd0,  64'd0,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'h3,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'h1,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'h0,         1'b0, 64'd0},
        '{1'b1, 7'd2,    32'd0,  64'd0,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd3,  64'h7,         1'b0, 64'd0},
        // partial frame, then a side change that drops it
        '{1'b1, 7'd5,    32'd0,  64'd0,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd2,  64'h1F,        1'b0, 64'd0},
        '{1'b1, 7'd4,    32'd0,  64'd0,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'h6,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'h9,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'h6,         1'b0, 64'd0},
        '{1'b0, 7'd0,    32'd1,  64'h0,         1'b0, 64'd0}
    };

    toroidal_life_generation_top #(
        .MAX_SIDE(64)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row_cells     (s_row_cells),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_next_row_cells(m_next_row_cells),
        .m_row_number    (m_row_number),
        .m_frame_end     (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned active_side(logic [tlg_pkg::SideW-1:0] v);
        if (v < 7'd3) begin
            return 3;
        end
        if (v > 7'd64) begin
            return 64;
        end
        return 32'(v);
    endfunction

    function automatic tlg_pkg::row_t live_bits(int unsigned side);
        if (side >= 64) begin
            return {tlg_pkg::CellW{1'b1}};
        end
        return (tlg_pkg::row_t'(1) << side) - tlg_pkg::row_t'(1);
    endfunction

    // B3/S23 on one row with wrap at the active side
    function automatic tlg_pkg::row_t life_next_row(tlg_pkg::row_t up, tlg_pkg::row_t mid,
                                                    tlg_pkg::row_t dn, int unsigned side);
        tlg_pkg::row_t nxt;
        int            xl;
        int            xr;
        int            cnt;
        nxt = '0;
        for (int x = 0; x < side; x++) begin
            xl  = (x == 0) ? side - 1 : x - 1;
            xr  = (x == side - 1) ? 0 : x + 1;
            cnt = int'(up[xl]) + int'(up[x]) + int'(up[xr]) + int'(mid[xl]) + int'(mid[xr])
                + int'(dn[xl]) + int'(dn[x]) + int'(dn[xr]);
            nxt[x] = (cnt == 3) || (mid[x] && cnt == 2);
        end
        return nxt;
    endfunction

    // absorb one accepted row; on the last row of a frame queue the next generation
    function automatic void absorb_row(tlg_pkg::row_t cells, bit fixed,
                                       tlg_pkg::row_t fixed_next);
        int unsigned side;
        int          yu;
        int          yd;
        gen_row_t    g;
        side = active_side(side_reg);
        if (rows_in_frame >= side) begin
            rows_in_frame = 0;
        end
        frame_rows[rows_in_frame] = cells & live_bits(side);
        rows_in_frame++;
        if (rows_in_frame == side) begin
            for (int y = 0; y < side; y++) begin
                yu = (y == 0) ? side - 1 : y - 1;
                yd = (y == side - 1) ? 0 : y + 1;
                g.cells = fixed ? fixed_next :
                          life_next_row(frame_rows[yu], frame_rows[y], frame_rows[yd], side);
                g.num   = tlg_pkg::RowNumW'(y);
                g.last  = (y == side - 1);
                pending_rows.push_back(g);
            end
            rows_in_frame = 0;
        end
    endfunction

    function automatic tlg_pkg::row_t rand_row();
        tlg_pkg::row_t a;
        tlg_pkg::row_t b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return a;
            1: return a & b;
            2: return a | b;
            default: return a & b & {$urandom, $urandom};
        endcase
    endfunction

    task automatic offer_row(tlg_pkg::row_t cells, bit fixed, tlg_pkg::row_t fixed_next);
        int gap;
        if ($urandom_range(0, 31) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_row_cells <= cells;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        absorb_row(cells, fixed, fixed_next);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_rows.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_side(logic [tlg_pkg::SideW-1:0] v);
        drain_results();
        // let any rows still loading settle
        repeat (16) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        side_reg      = v;
        rows_in_frame = 0;
    endtask

    // sender and config
    initial begin
        logic [tlg_pkg::SideW-1:0] side_val;
        int unsigned               side;
        int                        frames;
        int                        part;
        int                        phase;
        int                        r;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_valid       <= 1'b0;
        s_row_cells   <= '0;
        side_reg       = tlg_pkg::GridSideReset;
        rows_in_frame  = 0;
        errors         = 0;
        rand_rows_sent = 0;
        tx_burst       = 1'b0;
        rx_hold_req    = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);

        foreach (dir_steps[i]) begin
            if (dir_steps[i].is_cfg) begin
                write_side(dir_steps[i].side_val);
            end else begin
                for (int k = 0; k < dir_steps[i].reps; k++) begin
                    offer_row(dir_steps[i].cells, dir_steps[i].fixed, dir_steps[i].fixed_next);
                end
            end
        end

        phase = 0;
        while (rand_rows_sent < 170) begin
            case (phase)
                0: begin
                    side_val = 7'd127;
                    frames   = 1;
                end
                1: begin
                    side_val = 7'd0;
                    frames   = 3;
                end
                2: begin
                    side_val = 7'd5;
                    frames   = 6;
                end
                default: begin
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        side_val = tlg_pkg::SideW'($urandom_range(65, 127));
                        frames   = 1;
                    end else if (r == 1) begin
                        side_val = tlg_pkg::SideW'($urandom_range(0, 2));
                        frames   = $urandom_range(2, 4);
                    end else if (r == 2) begin
                        side_val = 7'd64;
                        frames   = 1;
                    end else if (r == 3) begin
                        side_val = tlg_pkg::SideW'($urandom_range(13, 63));
                        frames   = 1;
                    end else begin
                        side_val = tlg_pkg::SideW'($urandom_range(3, 12));
                        frames   = $urandom_range(2, 4);
                    end
                end
            endcase
            write_side(side_val);
            side = active_side(side_val);
            // hold the result side off long enough to back up the input
            if (phase == 2) begin
                rx_hold_req = 1'b1;
            end
            for (int f = 0; f < frames; f++) begin
                if (phase > 2 && $urandom_range(0, 7) == 0) begin
                    drain_results();
                end
                for (int y = 0; y < side; y++) begin
                    offer_row(rand_row(), 1'b0, '0);
                    rand_rows_sent++;
                end
            end
            // leave a broken frame for the next side write to drop
            if ($urandom_range(0, 3) == 0) begin
                part = $urandom_range(1, side - 1);
                for (int y = 0; y < part; y++) begin
                    offer_row(rand_row(), 1'b0, '0);
                    rand_rows_sent++;
                end
            end
            phase++;
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // result side
    initial begin
        int       gap;
        gen_row_t want;
        m_ready  <= 1'b0;
        rx_burst  = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                rx_burst = !rx_burst;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 8);
            if (rx_hold_req) begin
                gap         = 300;
                rx_hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!(m_valid && m_ready));
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected transaction row %0d cells %h", $time,
                         m_row_number, m_next_row_cells);
                errors++;
            end else begin
                want = pending_rows.pop_front();
                if (m_next_row_cells !== want.cells) begin
                    $display("%0t: next_row_cells expected %h actual %h", $time,
                             want.cells, m_next_row_cells);
                    errors++;
                end
                if (m_row_number !== want.num) begin
                    $display("%0t: row_number expected %0d actual %0d", $time,
                             want.num, m_row_number);
                    errors++;
                end
                if (m_frame_end !== want.last) begin
                    $display("%0t: frame_end expected %0b actual %0b", $time,
                             want.last, m_frame_end);
                    errors++;
                end
            end
        end
    end

endmodule
